### src/mppp_pkg.sv
package mppp_pkg;

    localparam int CMD_W    = 2;
    localparam int X_W      = 7;
    localparam int Y_W      = 6;
    localparam int COLOUR_W = 16;
    localparam int INDEX_W  = 10;
    localparam int BYTE_W   = 8;
    localparam int BIT_W    = 3;

    localparam int PWIDTH_W  = 8;
    localparam int PHEIGHT_W = 7;
    localparam int REG_W     = 8;
    localparam int REG_IDX_W = 1;

    localparam logic [PWIDTH_W-1:0]  PWIDTH_RESET  = 8'd128;
    localparam logic [PHEIGHT_W-1:0] PHEIGHT_RESET = 7'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic             rd;
        logic             wr;
        logic             wr_zero;
        logic [BIT_W-1:0] bit_sel;
    } t_mem_op;

endpackage

### src/mppp_if.sv
interface mppp_item_if import mppp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [X_W-1:0]      pixel_x;
    logic [Y_W-1:0]      pixel_y;
    logic [COLOUR_W-1:0] pixel_colour;
    logic [INDEX_W-1:0]  read_index;

    modport source (output valid, command, pixel_x, pixel_y, pixel_colour, read_index,
                    input ready);
    modport sink   (input valid, command, pixel_x, pixel_y, pixel_colour, read_index,
                    output ready);
endinterface

interface mppp_result_if import mppp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  page_byte;
    logic [INDEX_W-1:0] byte_index;

    modport source (output valid, page_byte, byte_index, input ready);
    modport sink   (input valid, page_byte, byte_index, output ready);
endinterface

interface mppp_cfg_if import mppp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/mppp_store.sv
module mppp_store import mppp_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  t_mem_op           i_op,
    input  logic [AW-1:0]     i_addr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic [BYTE_W-1:0] n_wdata;

    // merge the lit bit into the byte read in the previous cycle, or write zero for a clear
    always_comb begin
        if (i_op.wr_zero) begin
            n_wdata = '0;
        end else begin
            n_wdata = r_rdata | (BYTE_W'(1) << i_op.bit_sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.rd) begin
            r_rdata <= r_mem[i_addr];
        end
        if (i_op.wr) begin
            r_mem[i_addr] <= n_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/mppp_ctrl.sv
module mppp_ctrl import mppp_pkg::*; #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int DEPTH      = 1024,
    parameter int AW         = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PWIDTH_W-1:0]  i_cols,
    input  logic [PHEIGHT_W-1:0] i_rows,
    mppp_item_if.sink            i_item,
    mppp_result_if.source        o_result,
    output t_mem_op              o_op,
    output logic [AW-1:0]        o_addr,
    input  logic [BYTE_W-1:0]    i_rdata
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MERGE,
        S_READ
    } t_state;

    localparam logic [AW-1:0]          LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [PWIDTH_W:0]      W_CAP     = (PWIDTH_W + 1)'(MAX_WIDTH);
    localparam logic [PHEIGHT_W:0]     H_CAP     = (PHEIGHT_W + 1)'(MAX_HEIGHT);
    localparam int                     IDX_W     = 14;
    localparam logic [IDX_W-1:0]       DEPTH_L   = IDX_W'(DEPTH);

    t_state               r_state;
    logic [AW-1:0]        r_clr_cnt;
    logic [AW-1:0]        r_addr;
    logic [BIT_W-1:0]     r_bit;
    logic [INDEX_W-1:0]   r_ridx;
    logic                 r_ridx_ok;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_page_byte;
    logic [INDEX_W-1:0]   r_byte_index;

    logic                 accept;
    logic [PWIDTH_W:0]    w_eff;
    logic [PHEIGHT_W:0]   h_eff;
    logic                 x_ok;
    logic                 y_ok;
    logic [IDX_W-1:0]     pix_idx;
    logic                 pix_hit;
    logic                 ridx_ok;

    assign accept = i_item.valid && i_item.ready;

    always_comb begin
        w_eff   = ({1'b0, i_cols} > W_CAP) ? W_CAP : {1'b0, i_cols};
        h_eff   = ({1'b0, i_rows} > H_CAP) ? H_CAP : {1'b0, i_rows};
        x_ok    = (PWIDTH_W + 1)'(i_item.pixel_x) < w_eff;
        y_ok    = (PHEIGHT_W + 1)'(i_item.pixel_y) < h_eff;
        pix_idx = IDX_W'(i_item.pixel_y[Y_W-1:BIT_W]) * IDX_W'(w_eff)
                  + IDX_W'(i_item.pixel_x);
        pix_hit = (i_item.pixel_colour != '0) && x_ok && y_ok && (pix_idx < DEPTH_L);
        ridx_ok = IDX_W'(i_item.read_index) < DEPTH_L;
    end

    always_comb begin
        o_op   = '0;
        o_addr = r_addr;
        unique case (r_state)
            S_CLEAR: begin
                o_op.wr      = 1'b1;
                o_op.wr_zero = 1'b1;
                o_addr       = r_clr_cnt;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.command)
                        CMD_PIXEL: begin
                            o_op.rd = pix_hit;
                            o_addr  = AW'(pix_idx);
                        end
                        CMD_READ: begin
                            o_op.rd = 1'b1;
                            o_addr  = AW'(i_item.read_index);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MERGE: begin
                o_op.wr      = 1'b1;
                o_op.bit_sel = r_bit;
            end
            S_READ: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result.valid && o_result.ready && r_state != S_READ) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_cnt == LAST_ADDR) begin
                        r_clr_cnt <= '0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_clr_cnt <= r_clr_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_item.command)
                            CMD_CLEAR: begin
                                r_state <= S_CLEAR;
                            end
                            CMD_PIXEL: begin
                                if (pix_hit) begin
                                    r_addr  <= AW'(pix_idx);
                                    r_bit   <= i_item.pixel_y[BIT_W-1:0];
                                    r_state <= S_MERGE;
                                end
                            end
                            CMD_READ: begin
                                r_ridx    <= i_item.read_index;
                                r_ridx_ok <= ridx_ok;
                                r_state   <= S_READ;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MERGE: begin
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid  <= 1'b1;
                        r_page_byte  <= r_ridx_ok ? i_rdata : '0;
                        r_byte_index <= r_ridx;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready        = (r_state == S_IDLE);
    assign o_result.valid      = r_out_valid;
    assign o_result.page_byte  = r_page_byte;
    assign o_result.byte_index = r_byte_index;

    a_merge_after_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> $past(accept && i_item.command == CMD_PIXEL))
        else $error("merge without a pixel transfer");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_READ))
        else $error("result raised without a read");

    a_clear_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr_cnt != LAST_ADDR)
        |=> (r_state == S_CLEAR && r_clr_cnt == $past(r_clr_cnt) + 1'b1))
        else $error("clear sweep did not advance");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_op.rd && o_op.wr))
        else $error("read and write issued together");

endmodule

### src/mono_page_pixel_packer.sv
// Page-format monochrome frame packer. Each item is a command: clear, pixel or read. A clear,
// and every reset, sweeps the whole page store writing zero at one byte per cycle, so the
// block takes no item until it has zeroed all MAX_WIDTH*MAX_HEIGHT/8 bytes (1024 at the
// defaults). A pixel is a store read, then a merged write-back; an unlit or off-panel
// pixel does neither. A read returns page_byte with byte_index once the output register
// is free; the result waits there while the next item is taken. The page store is
// single-port, which sets this order. Configure the width and height registers only while idle.
module mono_page_pixel_packer import mppp_pkg::*; #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mppp_cfg_if.sink      i_cfg,
    mppp_item_if.sink     i_item,
    mppp_result_if.source o_result
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT / 8;
    localparam int AW    = $clog2(DEPTH);

    logic [PWIDTH_W-1:0]  r_cols;
    logic [PHEIGHT_W-1:0] r_rows;
    t_mem_op              mem_op;
    logic [AW-1:0]        mem_addr;
    logic [BYTE_W-1:0]    mem_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= PWIDTH_RESET;
            r_rows <= PHEIGHT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_COLS: begin
                    r_cols <= i_cfg.data[PWIDTH_W-1:0];
                end
                REG_ROWS: begin
                    r_rows <= i_cfg.data[PHEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mppp_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cols   (r_cols),
        .i_rows   (r_rows),
        .i_item   (i_item),
        .o_result (o_result),
        .o_op     (mem_op),
        .o_addr   (mem_addr),
        .i_rdata  (mem_rdata)
    );

    mppp_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_op    (mem_op),
        .i_addr  (mem_addr),
        .o_rdata (mem_rdata)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mppp_pkg::*;

    localparam int MAX_W        = 128;
    localparam int MAX_H        = 64;
    localparam int DEPTH        = MAX_W * MAX_H / 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]  page_byte;
        logic [INDEX_W-1:0] byte_index;
    } t_readback;

    logic i_clk;
    logic i_rst_n;

    mppp_cfg_if    cfg_if ();
    mppp_item_if   item_if ();
    mppp_result_if result_if ();

    mono_page_pixel_packer #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_item   (item_if),
        .o_result (result_if)
    );

    logic [BYTE_W-1:0]    frame_mem [DEPTH];
    logic [PWIDTH_W-1:0]  cur_width;
    logic [PHEIGHT_W-1:0] cur_height;
    t_readback            readback_q [$];
    int                   err_count     = 0;
    int                   burst_left    = 0;
    int                   max_gap       = 0;
    int                   max_burst     = 16;
    logic [15:0]          ready_pattern = '1;
    int                   pat_pos       = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int eff_width();
        return (cur_width > MAX_W) ? MAX_W : int'(cur_width);
    endfunction

    function automatic int eff_height();
        return (cur_height > MAX_H) ? MAX_H : int'(cur_height);
    endfunction

    function automatic void update_frame(logic [CMD_W-1:0] cmd, logic [X_W-1:0] x,
            logic [Y_W-1:0] y, logic [COLOUR_W-1:0] colour, logic [INDEX_W-1:0] ridx);
        int        ew;
        int        eh;
        int        idx;
        t_readback rb;
        ew = eff_width();
        eh = eff_height();
        case (cmd)
            CMD_CLEAR: begin
                foreach (frame_mem[i]) frame_mem[i] = '0;
            end
            CMD_PIXEL: begin
                idx = (int'(y) / 8) * ew + int'(x);
                if (colour != '0 && int'(x) < ew && int'(y) < eh && idx < DEPTH)
                    frame_mem[idx][y % 8] = 1'b1;
            end
            CMD_READ: begin
                rb.page_byte  = (int'(ridx) < DEPTH) ? frame_mem[ridx] : '0;
                rb.byte_index = ridx;
                readback_q.push_back(rb);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [COLOUR_W-1:0] random_colour();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick < 3)
            return COLOUR_W'(1) << $urandom_range(0, COLOUR_W - 1);
        return COLOUR_W'($urandom);
    endfunction

    function automatic logic [INDEX_W-1:0] panel_index(int ew, int eh);
        int pages;
        if (ew == 0 || eh == 0)
            return INDEX_W'($urandom);
        pages = (eh + 7) / 8;
        return INDEX_W'($urandom_range(0, pages - 1) * ew + $urandom_range(0, ew - 1));
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [X_W-1:0] x, logic [Y_W-1:0] y,
            logic [COLOUR_W-1:0] colour, logic [INDEX_W-1:0] ridx);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, max_gap);
            burst_left = $urandom_range(1, max_burst);
            if (gap > 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item_if.valid        <= 1'b1;
        item_if.command      <= cmd;
        item_if.pixel_x      <= x;
        item_if.pixel_y      <= y;
        item_if.pixel_colour <= colour;
        item_if.read_index   <= ridx;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        update_frame(cmd, x, y, colour, ridx);
    endtask

    task automatic settle_block();
        send_item(CMD_READ, X_W'($urandom), Y_W'($urandom), COLOUR_W'($urandom),
                  INDEX_W'($urandom));
        item_if.valid <= 1'b0;
        burst_left = 0;
        while (readback_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_panel(logic [REG_W-1:0] w_data, logic [REG_W-1:0] h_data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_COLS;
        cfg_if.data  <= w_data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cur_width = w_data;
        cfg_if.index <= REG_ROWS;
        cfg_if.data  <= h_data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cur_height = h_data[PHEIGHT_W-1:0];
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_traffic(bit busy);
        if (busy) begin
            max_gap       = $urandom_range(1, 6);
            max_burst     = $urandom_range(1, 12);
            ready_pattern <= 16'($urandom) | 16'h0001;
        end else begin
            max_gap       = 0;
            max_burst     = 16;
            ready_pattern <= '1;
        end
    endtask

    task automatic pixel(int x, int y, logic [COLOUR_W-1:0] colour);
        send_item(CMD_PIXEL, X_W'(x), Y_W'(y), colour, INDEX_W'($urandom));
    endtask

    task automatic read_byte(int idx);
        send_item(CMD_READ, X_W'($urandom), Y_W'($urandom), COLOUR_W'($urandom), INDEX_W'(idx));
    endtask

    task automatic test_after_reset();
        set_traffic(1'b0);
        read_byte(0);
        read_byte(DEPTH - 1);
        read_byte(511);
    endtask

    task automatic test_default_panel();
        set_traffic(1'b1);
        pixel(0, 0, 16'h0001);
        pixel(127, 31, 16'hFFFF);
        pixel(5, 9, 16'h0000);
        pixel(5, 32, 16'h8000);
        pixel(0, 1, 16'h0400);
        send_item(CMD_UNUSED, '0, '0, '1, '0);
        read_byte(0);
        read_byte(511);
        read_byte(133);
        read_byte(517);
        send_item(CMD_CLEAR, X_W'($urandom), Y_W'($urandom), COLOUR_W'($urandom),
                  INDEX_W'($urandom));
        read_byte(0);
        read_byte(511);
    endtask

    task automatic test_panel_limits();
        settle_block();
        write_panel(8'd255, 8'hFF);
        set_traffic(1'b0);
        pixel(127, 63, 16'h0001);
        read_byte(DEPTH - 1);
        settle_block();
        write_panel(8'd0, 8'd13);
        pixel(0, 0, 16'hFFFF);
        read_byte(0);
        settle_block();
        write_panel(8'd1, 8'd13);
        set_traffic(1'b1);
        pixel(0, 12, 16'h0020);
        pixel(0, 13, 16'h0020);
        pixel(1, 0, 16'h0020);
        read_byte(1);
        read_byte(0);
        settle_block();
        write_panel(8'd128, 8'd8);
        pixel(10, 7, 16'h4000);
        pixel(10, 8, 16'h4000);
        read_byte(10);
        read_byte(138);
    endtask

    task automatic test_random_traffic();
        int               done_items;
        int               pick;
        int               n;
        int               ew;
        int               eh;
        logic [REG_W-1:0] w_data;
        logic [REG_W-1:0] h_data;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 6))
                0:       w_data = 8'd0;
                1:       w_data = 8'd1;
                2:       w_data = 8'd128;
                3:       w_data = 8'd255;
                default: w_data = REG_W'($urandom_range(1, 128));
            endcase
            case ($urandom_range(0, 6))
                0:       h_data = 8'd8;
                1:       h_data = {1'($urandom), 7'd64};
                2:       h_data = {1'($urandom), 7'd127};
                3:       h_data = REG_W'($urandom);
                4:       h_data = REG_W'($urandom_range(1, 63));
                default: h_data = REG_W'($urandom_range(8, 64));
            endcase
            settle_block();
            write_panel(w_data, h_data);
            set_traffic($urandom_range(0, 3) != 0);
            ew = eff_width();
            eh = eff_height();
            if ($urandom_range(0, 2) == 0) begin
                send_item(CMD_CLEAR, X_W'($urandom), Y_W'($urandom), COLOUR_W'($urandom),
                          INDEX_W'($urandom));
                done_items++;
            end
            n = $urandom_range(40, 120);
            repeat (n) begin
                pick = $urandom_range(0, 99);
                if (pick < 55 && ew > 0 && eh > 0) begin
                    pixel($urandom_range(0, ew - 1), $urandom_range(0, eh - 1), random_colour());
                    done_items++;
                end else if (pick < 85) begin
                    read_byte(panel_index(ew, eh));
                    done_items++;
                end else if (pick < 93) begin
                    send_item(CMD_PIXEL, X_W'($urandom), Y_W'($urandom), random_colour(),
                              INDEX_W'($urandom));
                    done_items++;
                end else if (pick < 97) begin
                    read_byte(INDEX_W'($urandom));
                    done_items++;
                end else if (pick < 99) begin
                    send_item(CMD_UNUSED, X_W'($urandom), Y_W'($urandom), COLOUR_W'($urandom),
                              INDEX_W'($urandom));
                    done_items++;
                end else begin
                    send_item(CMD_CLEAR, X_W'($urandom), Y_W'($urandom), COLOUR_W'($urandom),
                              INDEX_W'($urandom));
                    done_items++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        result_if.ready <= ready_pattern[pat_pos];
        pat_pos         <= (pat_pos + 1) % 16;
    end

    always @(posedge i_clk) begin
        t_readback exp_rb;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (readback_q.size() == 0) begin
                $error("unexpected transfer: page_byte %0h byte_index %0d",
                       result_if.page_byte, result_if.byte_index);
                err_count++;
            end else begin
                exp_rb = readback_q.pop_front();
                if (result_if.page_byte !== exp_rb.page_byte) begin
                    $error("page_byte mismatch: expected %0h actual %0h",
                           exp_rb.page_byte, result_if.page_byte);
                    err_count++;
                end
                if (result_if.byte_index !== exp_rb.byte_index) begin
                    $error("byte_index mismatch: expected %0d actual %0d",
                           exp_rb.byte_index, result_if.byte_index);
                    err_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        item_if.valid        <= 1'b0;
        item_if.command      <= CMD_CLEAR;
        item_if.pixel_x      <= '0;
        item_if.pixel_y      <= '0;
        item_if.pixel_colour <= '0;
        item_if.read_index   <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= REG_COLS;
        cfg_if.data          <= '0;
        foreach (frame_mem[i]) frame_mem[i] = '0;
        cur_width  = PWIDTH_RESET;
        cur_height = PHEIGHT_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_default_panel();
        test_panel_limits();
        test_random_traffic();

        item_if.valid <= 1'b0;
        while (readback_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### mono_page_pixel_packer.f
src/mppp_pkg.sv
src/mppp_if.sv
src/mppp_store.sv
src/mppp_ctrl.sv
src/mono_page_pixel_packer.sv
tb/sv/tb_top.sv
